### hw/rtl/osva_pkg.sv
// ----------------------------------------------------------------------------
// osva_pkg
// Shared types and constants for the oxygen sensor vote and average block.
// ----------------------------------------------------------------------------
package osva_pkg;

  localparam int SENSOR_COUNT = 3;
  localparam int PPO2_W       = 8;
  localparam int VOLT_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int SUM_W        = 10;  // three readings of 8 bits

  // floor(x / 3) as (x * 683) >> 11, exact for x up to 765
  localparam logic [10:0] THIRD_RECIP = 11'd683;
  localparam int          THIRD_SHIFT = 11;
  localparam int          PROD_W      = SUM_W + 11;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEACTIVATED_MASK = 3'd0,
    REG_VOLT_LOW         = 3'd1,
    REG_VOLT_HIGH        = 3'd2,
    REG_DEVIATION_LIMIT  = 3'd3,
    REG_FALLBACK_ENABLE  = 3'd4,
    REG_FIXED_SETPOINT   = 3'd5,
    REG_DEBOUNCE_LIMIT   = 3'd6
  } cfg_reg_t;

  // configuration reset values
  localparam logic [SENSOR_COUNT-1:0] RST_DEACTIVATED_MASK = '0;
  localparam logic [VOLT_W-1:0]       RST_VOLT_LOW         = 16'd80;
  localparam logic [VOLT_W-1:0]       RST_VOLT_HIGH        = 16'd2500;
  localparam logic [PPO2_W-1:0]       RST_DEVIATION_LIMIT  = 8'd15;
  localparam logic                    RST_FALLBACK_ENABLE  = 1'b0;
  localparam logic [PPO2_W-1:0]       RST_FIXED_SETPOINT   = 8'd100;
  localparam logic [PPO2_W-1:0]       RST_DEBOUNCE_LIMIT   = 8'd100;

  localparam logic [PPO2_W-1:0] RUN_MAX = 8'd255;

  // what one lane found about its sensor
  typedef struct packed {
    logic window_fault;  // masked off or voltage outside the window
    logic deviates;      // differs by more than the limit from both others
  } lane_result_t;

  // stage one contents handed to the merge stage
  typedef struct packed {
    logic [SENSOR_COUNT-1:0]             window_fault;
    logic [SENSOR_COUNT-1:0]             deviates;
    logic [SENSOR_COUNT-1:0][PPO2_W-1:0] ppo2;
  } stage1_t;

  // settings the merge stage needs
  typedef struct packed {
    logic              fallback_enable;
    logic [PPO2_W-1:0] fixed_setpoint;
    logic [PPO2_W-1:0] debounce_limit;
  } merge_cfg_t;

endpackage

### hw/rtl/osva_if.sv
// ----------------------------------------------------------------------------
// osva_if
// Valid/ready channels for sensor items and voted results.
// ----------------------------------------------------------------------------
interface osva_in_if;
  import osva_pkg::*;

  logic              valid;
  logic              ready;
  logic [PPO2_W-1:0] ppo2_a;
  logic [PPO2_W-1:0] ppo2_b;
  logic [PPO2_W-1:0] ppo2_c;
  logic [VOLT_W-1:0] volt_a;
  logic [VOLT_W-1:0] volt_b;
  logic [VOLT_W-1:0] volt_c;

  modport source (output valid, ppo2_a, ppo2_b, ppo2_c, volt_a, volt_b, volt_c,
                  input ready);
  modport sink (input valid, ppo2_a, ppo2_b, ppo2_c, volt_a, volt_b, volt_c,
                output ready);
endinterface

interface osva_out_if;
  import osva_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PPO2_W-1:0]       result_cbar;
  logic [SENSOR_COUNT-1:0] fault_mask;
  logic                    held_value;
  logic                    fallback_taken;

  modport source (output valid, result_cbar, fault_mask, held_value, fallback_taken,
                  input ready);
  modport sink (input valid, result_cbar, fault_mask, held_value, fallback_taken,
                output ready);
endinterface

### hw/rtl/osva_lane.sv
// ----------------------------------------------------------------------------
// osva_lane
// Rates one sensor: voltage window, user mask and deviation from the others.
// ----------------------------------------------------------------------------
module osva_lane (
  input  logic [osva_pkg::PPO2_W-1:0] ppo2_own,
  input  logic [osva_pkg::PPO2_W-1:0] ppo2_x,
  input  logic [osva_pkg::PPO2_W-1:0] ppo2_y,
  input  logic [osva_pkg::VOLT_W-1:0] volt,
  input  logic                        masked,
  input  logic [osva_pkg::VOLT_W-1:0] volt_low,
  input  logic [osva_pkg::VOLT_W-1:0] volt_high,
  input  logic [osva_pkg::PPO2_W-1:0] deviation_limit,
  output osva_pkg::lane_result_t      result
);
  import osva_pkg::*;

  logic [PPO2_W-1:0] diff_x;
  logic [PPO2_W-1:0] diff_y;

  // absolute differences to the two other readings
  always_comb begin
    diff_x = (ppo2_own > ppo2_x) ? (ppo2_own - ppo2_x) : (ppo2_x - ppo2_own);
    diff_y = (ppo2_own > ppo2_y) ? (ppo2_own - ppo2_y) : (ppo2_y - ppo2_own);
  end

  // inclusive window, limit itself passes
  always_comb begin
    result.window_fault = masked || (volt < volt_low) || (volt > volt_high);
    result.deviates     = (diff_x > deviation_limit) && (diff_y > deviation_limit);
  end

endmodule

### hw/rtl/osva_merge.sv
// ----------------------------------------------------------------------------
// osva_merge
// Combines the lane findings, averages the good readings, runs the fault
// debounce and fallback, and holds the result register.
// ----------------------------------------------------------------------------
module osva_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  osva_pkg::stage1_t    s1,
  input  osva_pkg::merge_cfg_t cfg,
  output logic                 s1_take,
  osva_out_if.source           out_ch
);
  import osva_pkg::*;

  logic [SENSOR_COUNT-1:0] faults;
  logic [SENSOR_COUNT-1:0] good;
  logic [SUM_W-1:0]        sum;
  logic [1:0]              count;
  logic [PROD_W-1:0]       prod;
  logic [PPO2_W-1:0]       mean;
  logic                    all_fault;
  logic [PPO2_W-1:0]       run_inc;
  logic                    fire;
  logic                    use_setpoint;

  logic [PPO2_W-1:0] last_valid;
  logic [PPO2_W-1:0] fault_run;
  logic              fallback_done;

  // result register frees up when empty or taken this cycle
  assign s1_take = s1_valid && (!out_ch.valid || out_ch.ready);

  // pairwise test only counts when every window test passed
  always_comb begin
    faults    = (|s1.window_fault) ? s1.window_fault : s1.deviates;
    good      = ~faults;
    all_fault = &faults;
  end

  // sum and count of good readings
  always_comb begin
    sum   = '0;
    count = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (good[i]) begin
        sum   = sum + SUM_W'(s1.ppo2[i]);
        count = count + 2'd1;
      end
    end
  end

  // floor mean; division by three through the reciprocal
  always_comb begin
    prod = PROD_W'(sum) * PROD_W'(THIRD_RECIP);
    case (count)
      2'd2:    mean = sum[PPO2_W:1];
      2'd3:    mean = prod[THIRD_SHIFT +: PPO2_W];
      default: mean = sum[PPO2_W-1:0];
    endcase
  end

  // debounce and one-shot fallback
  always_comb begin
    run_inc      = (fault_run == RUN_MAX) ? RUN_MAX : fault_run + 8'd1;
    fire         = all_fault && (run_inc >= cfg.debounce_limit) &&
                   cfg.fallback_enable && !fallback_done;
    use_setpoint = fire && (cfg.fixed_setpoint != '0);
  end

  // result register and voting state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid  <= 1'b0;
      last_valid    <= '0;
      fault_run     <= '0;
      fallback_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && !s1_take) begin
        out_ch.valid <= 1'b0;
      end
      if (s1_take) begin
        out_ch.valid          <= 1'b1;
        out_ch.fault_mask     <= faults;
        out_ch.fallback_taken <= fire;
        if (all_fault) begin
          fault_run <= run_inc;
          if (fire) begin
            fallback_done <= 1'b1;
          end
          out_ch.result_cbar <= use_setpoint ? cfg.fixed_setpoint : last_valid;
          out_ch.held_value  <= !use_setpoint;
        end else begin
          fault_run          <= '0;
          last_valid         <= mean;
          out_ch.result_cbar <= mean;
          out_ch.held_value  <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/oxygen_sensor_vote_average.sv
// ----------------------------------------------------------------------------
// oxygen_sensor_vote_average
// Two-out-of-three oxygen sensor voting with a held value and a fixed
// setpoint fallback.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries three ppO2 readings (centibar) and three cell voltages
//   (100 uV units); out_ch returns one result per transaction: the voted
//   mean, the per-sensor fault mask and the held / fallback flags.
//   Settings are written through cfg_we / cfg_index / cfg_data while idle;
//   an index beyond the register list is ignored.
//   An input transaction passes the stage one register, after the three
//   sensor lanes, and then the result register, after the merge stage,
//   on its way to the result transaction.
//   in_ch takes a new item only while the single stage one register
//   between the lanes and the merge stage is empty.
//   When out_ch stalls, the result register holds, stage one fills with the
//   next item and in_ch then drops ready until the result is taken.
//   Reset clears the pipeline, the last valid value, the fault run counter
//   and the fallback flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module oxygen_sensor_vote_average (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [osva_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [osva_pkg::CFG_DATA_W-1:0]  cfg_data,
  osva_in_if.sink                          in_ch,
  osva_out_if.source                       out_ch
);
  import osva_pkg::*;

  // configuration registers
  logic [SENSOR_COUNT-1:0] deactivated_mask;
  logic [VOLT_W-1:0]       volt_low;
  logic [VOLT_W-1:0]       volt_high;
  logic [PPO2_W-1:0]       deviation_limit;
  logic                    fallback_enable;
  logic [PPO2_W-1:0]       fixed_setpoint;
  logic [PPO2_W-1:0]       debounce_limit;

  logic [SENSOR_COUNT-1:0][PPO2_W-1:0] ppo2_in;
  logic [SENSOR_COUNT-1:0][VOLT_W-1:0] volt_in;
  lane_result_t                        lane_res [SENSOR_COUNT];
  stage1_t                             s1;
  stage1_t                             s1_next;
  logic                                s1_valid;
  logic                                s1_take;
  logic                                in_take;
  merge_cfg_t                          merge_cfg;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      deactivated_mask <= RST_DEACTIVATED_MASK;
      volt_low         <= RST_VOLT_LOW;
      volt_high        <= RST_VOLT_HIGH;
      deviation_limit  <= RST_DEVIATION_LIMIT;
      fallback_enable  <= RST_FALLBACK_ENABLE;
      fixed_setpoint   <= RST_FIXED_SETPOINT;
      debounce_limit   <= RST_DEBOUNCE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEACTIVATED_MASK: deactivated_mask <= cfg_data[SENSOR_COUNT-1:0];
        REG_VOLT_LOW:         volt_low         <= cfg_data[VOLT_W-1:0];
        REG_VOLT_HIGH:        volt_high        <= cfg_data[VOLT_W-1:0];
        REG_DEVIATION_LIMIT:  deviation_limit  <= cfg_data[PPO2_W-1:0];
        REG_FALLBACK_ENABLE:  fallback_enable  <= cfg_data[0];
        REG_FIXED_SETPOINT:   fixed_setpoint   <= cfg_data[PPO2_W-1:0];
        REG_DEBOUNCE_LIMIT:   debounce_limit   <= cfg_data[PPO2_W-1:0];
        default: ;
      endcase
    end
  end

  // one item in flight in stage one
  assign in_ch.ready = !s1_valid;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign ppo2_in = {in_ch.ppo2_c, in_ch.ppo2_b, in_ch.ppo2_a};
  assign volt_in = {in_ch.volt_c, in_ch.volt_b, in_ch.volt_a};

  // one lane per sensor
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    osva_lane u_lane (
      .ppo2_own        (ppo2_in[g]),
      .ppo2_x          (ppo2_in[(g + 1) % SENSOR_COUNT]),
      .ppo2_y          (ppo2_in[(g + 2) % SENSOR_COUNT]),
      .volt            (volt_in[g]),
      .masked          (deactivated_mask[g]),
      .volt_low        (volt_low),
      .volt_high       (volt_high),
      .deviation_limit (deviation_limit),
      .result          (lane_res[g])
    );
  end

  // gather lane findings
  always_comb begin
    s1_next.ppo2 = ppo2_in;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      s1_next.window_fault[i] = lane_res[i].window_fault;
      s1_next.deviates[i]     = lane_res[i].deviates;
    end
  end

  // stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= 1'b0;
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1 <= s1_next;
    end
  end

  assign merge_cfg.fallback_enable = fallback_enable;
  assign merge_cfg.fixed_setpoint  = fixed_setpoint;
  assign merge_cfg.debounce_limit  = debounce_limit;

  osva_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .cfg      (merge_cfg),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

  // a result with a good sensor is never held or a fallback
  a_good_not_held: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.fault_mask != {SENSOR_COUNT{1'b1}}) |->
      !out_ch.held_value && !out_ch.fallback_taken)
    else $error("good result flagged as held or fallback");

  // an accepted item lands in stage one
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted item lost before stage one");

  // a waiting stage one item holds until the merge stage takes it
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_take |=> s1_valid && $stable(s1))
    else $error("stage one item changed while waiting");

  // stage one handing over always yields a result next cycle
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    s1_take |=> out_ch.valid)
    else $error("merge stage dropped an item");

endmodule
